/* rtl/sitda_pkg.sv */
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared constants and the decade table for the integer-to-decimal converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

  // Decades covered by the table: 10^0 .. 10^18 spans any magnitude up to 2^63
  localparam int NUM_DECADES = 19;
  localparam int DEC_BITS    = 5;
  localparam int NUM_DIGITS  = 10;
  localparam int DIGIT_BITS  = 4;
  localparam int TBL_BITS    = 64;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = 1;
  localparam int CNT_BITS    = 2;

  // Table of d * 10^k for every decade k and digit d
  typedef logic [NUM_DECADES-1:0][NUM_DIGITS-1:0][TBL_BITS-1:0] mult_tbl_t;

  function automatic mult_tbl_t build_mult_tbl();
    mult_tbl_t           t;
    logic [TBL_BITS-1:0] p;
    p = TBL_BITS'(1);
    for (int k = 0; k < NUM_DECADES; k++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        t[k][d] = p * TBL_BITS'(d);
      end
      p = p * TBL_BITS'(10);
    end
    return t;
  endfunction

  localparam mult_tbl_t MULT_TBL = build_mult_tbl();

endpackage

/* rtl/sitda_in_if.sv */
// ----------------------------------------------------------------------------
// sitda_in_if
// Input channel: one signed integer per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sitda_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* rtl/sitda_out_if.sv */
// ----------------------------------------------------------------------------
// sitda_out_if
// Output channel: one ASCII character per item, with an end-of-text flag.
// ----------------------------------------------------------------------------
interface sitda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

/* rtl/sitda_front.sv */
// ----------------------------------------------------------------------------
// sitda_front
// Accepts integers, splits them into sign and magnitude and finds the leading
// decade, then hands the job to the queue.
// ----------------------------------------------------------------------------
module sitda_front #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                        clk,
  input  logic                                        rst,
  sitda_in_if.sink                                    in_ch,
  output logic                                        job_valid,
  input  logic                                        job_ready,
  output logic [VALUE_BITS+sitda_pkg::DEC_BITS:0]     job
);

  logic                         stage_valid;
  logic        [VALUE_BITS-1:0] stage_value;
  logic                         neg;
  logic        [VALUE_BITS-1:0] mag;
  logic [sitda_pkg::DEC_BITS-1:0] top_dec;

  // Input register; refills as soon as the queue takes the held item
  assign in_ch.ready = !stage_valid || job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stage_value <= in_ch.value;
    end
  end

  // Sign and magnitude; the most negative value wraps to 2^(N-1) unsigned
  assign neg = stage_value[VALUE_BITS-1];
  assign mag = neg ? (~stage_value + VALUE_BITS'(1)) : stage_value;

  // Highest decade not above the magnitude (zero gives decade 0)
  always_comb begin
    top_dec = '0;
    for (int k = 1; k < sitda_pkg::NUM_DECADES; k++) begin
      if (sitda_pkg::TBL_BITS'(mag) >= sitda_pkg::MULT_TBL[k][1]) begin
        top_dec = sitda_pkg::DEC_BITS'(k);
      end
    end
  end

  assign job_valid = stage_valid;
  assign job       = {neg, top_dec, mag};

endmodule

/* rtl/sitda_queue.sv */
// ----------------------------------------------------------------------------
// sitda_queue
// Short register queue that decouples the front from the digit emitter.
// ----------------------------------------------------------------------------
module sitda_queue #(
  parameter int WIDTH = 38
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0]                 slots [sitda_pkg::QUEUE_DEPTH];
  logic [sitda_pkg::PTR_BITS-1:0]   wr_ptr;
  logic [sitda_pkg::PTR_BITS-1:0]   rd_ptr;
  logic [sitda_pkg::CNT_BITS-1:0]   count;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (count != sitda_pkg::CNT_BITS'(sitda_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/sitda_back.sv */
// ----------------------------------------------------------------------------
// sitda_back
// Emits a '-' for negative numbers, then one decimal digit per cycle while
// not stalled, most significant first, into a registered output stage.
// ----------------------------------------------------------------------------
module sitda_back #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    job_valid,
  output logic                                    job_ready,
  input  logic [VALUE_BITS+sitda_pkg::DEC_BITS:0] job,
  sitda_out_if.source                             out_ch
);

  logic                             busy;
  logic                             neg_pend;
  logic [VALUE_BITS-1:0]            rem;
  logic [sitda_pkg::DEC_BITS-1:0]   dec;
  logic                             out_valid;
  logic [7:0]                       out_char;
  logic                             out_last;
  logic                             advance;
  logic [sitda_pkg::DIGIT_BITS-1:0] digit;
  logic [VALUE_BITS-1:0]            rem_next;
  logic [sitda_pkg::TBL_BITS:0]     diff;

  assign job_ready = !busy;
  assign advance   = busy && (!out_valid || out_ch.ready);

  // Digit of the current decade: largest multiple that still fits
  always_comb begin
    digit    = '0;
    rem_next = rem;
    diff     = '0;
    for (int d = 1; d < sitda_pkg::NUM_DIGITS; d++) begin
      diff = {1'b0, sitda_pkg::TBL_BITS'(rem)} - {1'b0, sitda_pkg::MULT_TBL[dec][d]};
      if (!diff[sitda_pkg::TBL_BITS]) begin
        digit    = sitda_pkg::DIGIT_BITS'(d);
        rem_next = diff[VALUE_BITS-1:0];
      end
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      neg_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!busy && job_valid) begin
        busy     <= 1'b1;
        neg_pend <= job[VALUE_BITS+sitda_pkg::DEC_BITS];
      end else if (advance) begin
        if (neg_pend) begin
          neg_pend <= 1'b0;
        end else if (dec == '0) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working magnitude, decade and output payload
  always_ff @(posedge clk) begin
    if (!busy && job_valid) begin
      rem <= job[VALUE_BITS-1:0];
      dec <= job[VALUE_BITS +: sitda_pkg::DEC_BITS];
    end else if (advance && !neg_pend) begin
      rem <= rem_next;
      dec <= dec - 1'b1;
    end
    if (advance) begin
      if (neg_pend) begin
        out_char <= sitda_pkg::ASCII_MINUS;
        out_last <= 1'b0;
      end else begin
        out_char <= sitda_pkg::ASCII_ZERO + {4'b0000, digit};
        out_last <= (dec == '0);
      end
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.char_code = out_char;
  assign out_ch.last_char = out_last;

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed integer to decimal ASCII text, one character per output item.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  takes one signed VALUE_BITS-bit integer per item (valid/ready).
//   out_ch gives its text one character per item, most significant first:
//   an optional '-', then the digits with no leading zeros; last_char marks
//   the final character. Zero gives a single '0'.
// With the block idle, an accepted item passes the input register, the
//   queue and the load into the digit sequencer before its first
//   character appears.
// The digit sequencer produces one character per cycle while the output
//   takes them, and loads each number in a step of its own before its
//   first character, so it takes no new number until the current one is sent.
// A two-entry queue sits between the classifier and the sequencer, so new
//   numbers are still taken while the output is stalled, until it fills.
// When the receiver holds ready low, the current character stays on the
//   output and the sequencer waits. Reset (rst, synchronous) empties the
//   queue and drops any partly sent number.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  sitda_in_if.sink    in_ch,
  sitda_out_if.source out_ch
);

  localparam int JOB_BITS = VALUE_BITS + sitda_pkg::DEC_BITS + 1;

  logic                front_valid;
  logic                front_ready;
  logic [JOB_BITS-1:0] front_job;
  logic                back_valid;
  logic                back_ready;
  logic [JOB_BITS-1:0] back_job;

  // Classify sign, magnitude and leading decade
  sitda_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  // Decoupling queue
  sitda_queue #(
    .WIDTH (JOB_BITS)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_job)
  );

  // Character sequencer
  sitda_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .job       (back_job),
    .out_ch    (out_ch)
  );

endmodule

/* sim/decimal_text_checker.sv */
// ----------------------------------------------------------------------------
// decimal_text_checker
// Watches both channels of the integer-to-decimal converter, predicts the
// text of every accepted number and compares it character by character.
// ----------------------------------------------------------------------------
module decimal_text_checker #(
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  sitda_in_if  in_mon,
  sitda_out_if out_mon,
  output int   error_count,
  output int   chars_outstanding
);

  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam int         MAX_DIGITS = 20;

  typedef struct {
    logic [7:0]            code;
    logic                  is_last;
    logic [VALUE_BITS-1:0] number;
  } text_char_t;

  text_char_t expected_chars[$];
  int         mismatches  = 0;
  int         outstanding = 0;

  assign error_count       = mismatches;
  assign chars_outstanding = outstanding;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Queue the decimal text of one number, sign first, then digits MSD first
  function automatic void spell_decimal(input logic [VALUE_BITS-1:0] number);
    logic [VALUE_BITS-1:0] magnitude;
    logic [3:0]            digit_buf[MAX_DIGITS];
    int                    n_digits;
    text_char_t            ch;
    // two's complement negate; the most negative value stays 2^(N-1) unsigned
    magnitude = number[VALUE_BITS-1] ? (~number + 1'b1) : number;
    n_digits  = 0;
    do begin
      digit_buf[n_digits] = 4'(magnitude % 10);
      magnitude           = magnitude / 10;
      n_digits++;
    end while (magnitude != 0 && n_digits < MAX_DIGITS);
    ch.number = number;
    if (number[VALUE_BITS-1]) begin
      ch.code    = CHAR_MINUS;
      ch.is_last = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      ch.code    = CHAR_ZERO + 8'(digit_buf[i]);
      ch.is_last = (i == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  // Compare outgoing characters first, then queue text for new numbers
  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                    out_mon.char_code, out_mon.last_char));
        end else begin
          want = expected_chars.pop_front();
          if (out_mon.char_code !== want.code)
            report_mismatch($sformatf("number %0d: char 0x%02h, expected 0x%02h",
                                      $signed(want.number), out_mon.char_code, want.code));
          if (out_mon.last_char !== want.is_last)
            report_mismatch($sformatf("number %0d: last_char %0b, expected %0b",
                                      $signed(want.number), out_mon.last_char,
                                      want.is_last));
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        spell_decimal(in_mon.value);
    end
    outstanding = expected_chars.size();
  end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives signed integers into the converter in random bursts, stalls the
// character output on shifting patterns, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int VALUE_BITS   = 32;
  localparam int NUM_RANDOM   = 430;
  localparam int NUM_DIRECTED = 20;
  localparam int CLK_PERIOD   = 12;
  localparam int DRAIN_CYCLES = 30;
  localparam int LIMIT_CYCLES = 200000;

  typedef enum int {RX_OPEN, RX_COIN, RX_CHOKED, RX_PERIODIC, RX_HOLD} rx_mode_e;

  logic clk;
  logic rst;
  int   error_count;
  int   chars_outstanding;

  // Extremes, digit-count boundaries, zero and both sign patterns
  logic [VALUE_BITS-1:0] directed_values[NUM_DIRECTED] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9,
    32'd10, 32'd99, 32'd100, -32'sd100, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE, 32'd1000000000, -32'sd1000000000,
    32'd999999999, 32'd1999999999, 32'h5555_5555, 32'hAAAA_AAAA, 32'd12345
  };

  sitda_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch();
  sitda_out_if out_ch();

  signed_int_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  decimal_text_checker #(.VALUE_BITS(VALUE_BITS)) i_checker (
    .clk               (clk),
    .rst               (rst),
    .in_mon            (in_ch),
    .out_mon           (out_ch),
    .error_count       (error_count),
    .chars_outstanding (chars_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Run limit
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("FAIL signed_int_to_decimal_ascii");
    $finish;
  end

  // Random number, weighted toward each digit count and the range ends
  function automatic logic [VALUE_BITS-1:0] pick_value();
    longint lo;
    longint hi;
    longint mag;
    int     n;
    bit     neg;
    neg = $urandom_range(0, 1);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: begin
        n  = $urandom_range(1, 10);
        lo = (n == 1) ? 0 : 1;
        for (int i = 1; i < n; i++) lo = lo * 10;
        hi = (n == 1) ? 9 : lo * 10 - 1;
        if (hi > 64'd2147483647) hi = 64'd2147483647;
        mag = lo + longint'($urandom) % (hi - lo + 1);
      end
      7: mag = $urandom_range(0, 20);
      8: begin
        mag = 64'd2147483647 - $urandom_range(0, 15);
        if (neg) mag = mag + 1;
      end
      default: begin
        mag = 1;
        n   = $urandom_range(0, 9);
        for (int i = 0; i < n; i++) mag = mag * 10;
        mag = mag + $urandom_range(0, 2) - 1;
      end
    endcase
    return VALUE_BITS'(neg ? -mag : mag);
  endfunction

  // Hold one number on the input until it is taken
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Receiver: ready follows a pattern that changes every stretch
  initial begin
    rx_mode_e mode;
    int       mode_left;
    int       phase;
    out_ch.ready = 1'b0;
    mode      = RX_OPEN;
    mode_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 4));
        mode_left = (mode == RX_HOLD) ? $urandom_range(4, 40) : $urandom_range(16, 160);
        phase     = 0;
      end
      mode_left--;
      case (mode)
        RX_OPEN:     out_ch.ready <= 1'b1;
        RX_COIN:     out_ch.ready <= $urandom_range(0, 1);
        RX_CHOKED:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: out_ch.ready <= ((phase % 5) < 3);
        default:     out_ch.ready <= 1'b0;
      endcase
      phase++;
    end
  end

  // Sender: directed numbers, then random ones, in bursts with gaps
  initial begin
    int sent;
    int burst;
    int gap;
    rst         = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    sent = 0;
    while (sent < NUM_DIRECTED + NUM_RANDOM) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst && sent < NUM_DIRECTED + NUM_RANDOM; k++) begin
        send_value((sent < NUM_DIRECTED) ? directed_values[sent] : pick_value());
        sent++;
      end
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain remaining text, then watch for stray characters
    while (chars_outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS signed_int_to_decimal_ascii");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sitda_pkg.sv
rtl/sitda_in_if.sv
rtl/sitda_out_if.sv
rtl/sitda_front.sv
rtl/sitda_queue.sv
rtl/sitda_back.sv
rtl/signed_int_to_decimal_ascii.sv
sim/decimal_text_checker.sv
sim/testbench.sv
